### hw/rtl/u16550_pkg.sv
// Shared types and constants for the 16550-style UART register block.
// No dependencies; every other file of the block but u16550_ram imports this package.
package u16550_pkg;

	// Default sizes, handed down as top-level parameter defaults
	localparam int RX_DEPTH_DEF       = 64;
	localparam int LOOPBACK_LIMIT_DEF = 16;

	// Field widths fixed by the bus and line formats
	localparam int ADDR_W    = 32;
	localparam int BYTE_W    = 8;
	localparam int KIND_W    = 2;
	localparam int RX_FREE_W = 7;
	localparam int REG_SEL_W = 3;
	localparam int IER_W     = 4;

	// Item kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_READ  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_RX    = 2'd2
	} kind_t;

	// Register offsets from the base address
	localparam logic [REG_SEL_W-1:0] REG_RBR_THR = 3'd0;
	localparam logic [REG_SEL_W-1:0] REG_IER     = 3'd1;
	localparam logic [REG_SEL_W-1:0] REG_IIR_FCR = 3'd2;
	localparam logic [REG_SEL_W-1:0] REG_LCR     = 3'd3;
	localparam logic [REG_SEL_W-1:0] REG_MCR     = 3'd4;
	localparam logic [REG_SEL_W-1:0] REG_LSR     = 3'd5;
	localparam logic [REG_SEL_W-1:0] REG_MSR     = 3'd6;
	localparam logic [REG_SEL_W-1:0] REG_SCR     = 3'd7;

	// Bit positions and fixed register values
	localparam int LCR_DLAB_BIT = 7;
	localparam int MCR_LOOP_BIT = 4;
	localparam int MCR_RTS_BIT  = 1;
	localparam int MCR_DTR_BIT  = 0;
	localparam int FCR_EN_BIT   = 0;
	localparam int FCR_CLR_BIT  = 1;
	localparam int IER_RX_BIT   = 0;
	localparam int IER_THR_BIT  = 1;

	localparam logic [BYTE_W-1:0] IIR_RX_CODE   = 8'h04;
	localparam logic [BYTE_W-1:0] IIR_THR_CODE  = 8'h02;
	localparam logic [BYTE_W-1:0] IIR_NONE_CODE = 8'h01;
	localparam logic [BYTE_W-1:0] IIR_FIFO_FLAG = 8'hC0;
	localparam logic [BYTE_W-1:0] LSR_IDLE      = 8'h60;
	localparam logic [BYTE_W-1:0] LSR_DR        = 8'h01;
	localparam logic [BYTE_W-1:0] MSR_LOOP_CTS  = 8'h10;
	localparam logic [BYTE_W-1:0] MSR_LOOP_DSR  = 8'h20;
	localparam logic [BYTE_W-1:0] MSR_NORMAL    = 8'h30;

	// One input item
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ADDR_W-1:0] address;
		logic [BYTE_W-1:0] data;
	} step_t;

	// One result item; pop marks read data that comes from the receive store
	typedef struct packed {
		logic                 pop;
		logic [BYTE_W-1:0]    read_data;
		logic                 irq;
		logic                 tx_valid;
		logic [BYTE_W-1:0]    tx_data;
		logic [RX_FREE_W-1:0] rx_free;
	} result_t;

endpackage

### hw/rtl/u16550_if.sv
// Handshake channels of the UART register block: items, results, config.
// Depends on u16550_pkg for field widths.
interface u16550_item_if import u16550_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [ADDR_W-1:0] address;
	logic [BYTE_W-1:0] data;

	modport source (output valid, kind, address, data, input ready);
	modport sink (input valid, kind, address, data, output ready);
endinterface

interface u16550_result_if import u16550_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [BYTE_W-1:0]    read_data;
	logic                 irq;
	logic                 tx_valid;
	logic [BYTE_W-1:0]    tx_data;
	logic [RX_FREE_W-1:0] rx_free;

	modport source (output valid, read_data, irq, tx_valid, tx_data, rx_free, input ready);
	modport sink (input valid, read_data, irq, tx_valid, tx_data, rx_free, output ready);
endinterface

interface u16550_cfg_if import u16550_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

### hw/rtl/uart_16550_register_model.sv
// Top level of the 16550-style UART register block.
// Depends on u16550_pkg, u16550_if, u16550_ram and u16550_regs.
//
// Usage:
//   item   - one beat is a bus byte read, a bus byte write or a character
//            received from the line (kind, address, data).
//   result - one beat per item, in order: read_data, irq, tx_valid,
//            tx_data, rx_free, all as they stand after that item.
//   cfg    - writes base_address; always ready, write only while idle.
// An item is taken into an input stage, decoded there against the register
// state, and its result is loaded into the result register at the next
// edge at which that register is free or being emptied. Throughput is one
// item per cycle while the receiver does not stall. RBR data comes from the
// receive store's registered read port, which is read as the item leaves
// the input stage, so the popped byte appears with its result beat.
// If the receiver stalls, the result register holds, the input stage
// fills, and item.ready drops until result.ready returns.
// Reset clears all registers, the FIFO pointers and both stages; the
// receive store needs no clearing pass.
module uart_16550_register_model import u16550_pkg::*; #(
	parameter int RX_DEPTH       = RX_DEPTH_DEF,
	parameter int LOOPBACK_LIMIT = LOOPBACK_LIMIT_DEF
) (
	input logic               clk,
	input logic               arst_n,
	u16550_cfg_if.sink        cfg,
	u16550_item_if.sink       item,
	u16550_result_if.source   result
);

	localparam int HW = $clog2(RX_DEPTH);

	logic [ADDR_W-1:0] base_q;
	logic              valid_s1;
	step_t             step_s1;
	logic              res_valid_q;
	result_t           res_q;
	result_t           res_d;
	logic              fire;

	logic              ram_we;
	logic [HW-1:0]     ram_waddr;
	logic [BYTE_W-1:0] ram_wdata;
	logic              ram_re;
	logic [HW-1:0]     ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;

	// configuration beat
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg.valid) begin
			base_q <= cfg.data;
		end
	end

	// handshake: input stage advances when the result register can take it
	assign fire       = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || fire;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			step_s1.kind    <= item.kind;
			step_s1.address <= item.address;
			step_s1.data    <= item.data;
		end
	end

	// register file and FIFO control
	u16550_regs #(
		.RX_DEPTH       (RX_DEPTH),
		.LOOPBACK_LIMIT (LOOPBACK_LIMIT)
	) u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.step         (step_s1),
		.base_address (base_q),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.res          (res_d)
	);

	// receive store
	u16550_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (RX_DEPTH)
	) u_rx_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_d;
		end
	end

	// popped bytes come straight from the store's read register
	assign result.valid     = res_valid_q;
	assign result.read_data = res_q.pop ? ram_rdata : res_q.read_data;
	assign result.irq       = res_q.irq;
	assign result.tx_valid  = res_q.tx_valid;
	assign result.tx_data   = res_q.tx_data;
	assign result.rx_free   = res_q.rx_free;

endmodule

### hw/rtl/u16550_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module u16550_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read; data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/u16550_regs.sv
// Register file, address decode and receive FIFO pointers of the UART.
// Depends on u16550_pkg; drives the receive store RAM ports.
module u16550_regs import u16550_pkg::*; #(
	parameter int RX_DEPTH       = RX_DEPTH_DEF,
	parameter int LOOPBACK_LIMIT = LOOPBACK_LIMIT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  step_t                       step,
	input  logic [ADDR_W-1:0]           base_address,
	output logic                        ram_we,
	output logic [$clog2(RX_DEPTH)-1:0] ram_waddr,
	output logic [BYTE_W-1:0]           ram_wdata,
	output logic                        ram_re,
	output logic [$clog2(RX_DEPTH)-1:0] ram_raddr,
	output result_t                     res
);

	localparam int HW    = $clog2(RX_DEPTH);
	localparam int CW    = $clog2(RX_DEPTH + 1);
	localparam int SUM_W = CW + 1;
	localparam int FW    = (CW > RX_FREE_W) ? CW : RX_FREE_W;

	// architectural state
	logic [HW-1:0]     head_q;
	logic [CW-1:0]     cnt_q;
	logic [BYTE_W-1:0] lcr_q;
	logic [BYTE_W-1:0] mcr_q;
	logic [IER_W-1:0]  ier_q;
	logic [BYTE_W-1:0] dll_q;
	logic [BYTE_W-1:0] dlm_q;
	logic [BYTE_W-1:0] scr_q;
	logic              fifo_on_q;
	logic              thr_empty_q;

	logic [HW-1:0]     head_d;
	logic [CW-1:0]     cnt_d;
	logic [IER_W-1:0]  ier_d;
	logic              thr_empty_d;

	// decode
	logic [ADDR_W-1:0]    offset;
	logic                 in_range;
	logic [REG_SEL_W-1:0] sel;
	logic                 dlab;
	logic                 loopback;
	logic                 not_empty;
	logic                 full;
	logic                 is_read;
	logic                 is_write;
	logic                 is_rx;
	logic                 thr_write;
	logic                 do_push;
	logic                 do_pop;
	logic                 fifo_clear;
	logic [SUM_W-1:0]     slot_sum;
	logic [SUM_W-1:0]     slot;
	logic [HW-1:0]        head_inc;
	logic [BYTE_W-1:0]    iir_now;
	logic [BYTE_W-1:0]    rd_mux;
	logic [FW-1:0]        free_w;

	assign offset    = step.address - base_address;
	assign in_range  = (offset[ADDR_W-1:REG_SEL_W] == '0);
	assign sel       = offset[REG_SEL_W-1:0];
	assign dlab      = lcr_q[LCR_DLAB_BIT];
	assign loopback  = mcr_q[MCR_LOOP_BIT];
	assign not_empty = (cnt_q != '0);
	assign full      = (cnt_q == CW'(RX_DEPTH));

	assign is_read   = (step.kind == KIND_READ) && in_range;
	assign is_write  = (step.kind == KIND_WRITE) && in_range;
	assign is_rx     = (step.kind == KIND_RX);
	assign thr_write = is_write && (sel == REG_RBR_THR) && !dlab;

	// FIFO push and pop, at most one per item
	assign do_pop  = is_read && (sel == REG_RBR_THR) && !dlab && not_empty;
	assign do_push = !full && (is_rx || (thr_write && loopback &&
		(32'(cnt_q) < 32'(LOOPBACK_LIMIT))));
	assign fifo_clear = is_write && (sel == REG_IIR_FCR) && step.data[FCR_CLR_BIT];

	// tail slot, wrapping at the store depth
	assign slot_sum = SUM_W'(head_q) + SUM_W'(cnt_q);
	assign slot     = (slot_sum >= SUM_W'(RX_DEPTH)) ? slot_sum - SUM_W'(RX_DEPTH) : slot_sum;
	assign head_inc = (head_q == HW'(RX_DEPTH - 1)) ? '0 : head_q + HW'(1);

	assign ram_we    = fire && do_push;
	assign ram_waddr = slot[HW-1:0];
	assign ram_wdata = step.data;
	assign ram_re    = fire && do_pop;
	assign ram_raddr = head_q;

	// next FIFO head and count, IER and THR-empty flag; all but the head feed the interrupt level
	always_comb begin
		head_d      = head_q;
		cnt_d       = cnt_q;
		ier_d       = ier_q;
		thr_empty_d = thr_empty_q;
		if (fifo_clear) begin
			head_d = '0;
			cnt_d  = '0;
		end else if (do_pop) begin
			head_d = head_inc;
			cnt_d  = cnt_q - CW'(1);
		end else if (do_push) begin
			cnt_d = cnt_q + CW'(1);
		end
		if (is_write && (sel == REG_IER) && !dlab) begin
			ier_d = step.data[IER_W-1:0];
		end
		if (thr_write) begin
			thr_empty_d = 1'b1;
		end
	end

	// interrupt identification before the item
	always_comb begin
		if (ier_q[IER_RX_BIT] && not_empty) begin
			iir_now = IIR_RX_CODE;
		end else if (ier_q[IER_THR_BIT] && thr_empty_q) begin
			iir_now = IIR_THR_CODE;
		end else begin
			iir_now = IIR_NONE_CODE;
		end
		if (fifo_on_q) begin
			iir_now = iir_now | IIR_FIFO_FLAG;
		end
	end

	// read data mux
	always_comb begin
		rd_mux = '0;
		case (sel)
			REG_RBR_THR: rd_mux = dlab ? dll_q : '0;
			REG_IER:     rd_mux = dlab ? dlm_q : BYTE_W'(ier_q);
			REG_IIR_FCR: rd_mux = iir_now;
			REG_LCR:     rd_mux = lcr_q;
			REG_MCR:     rd_mux = mcr_q;
			REG_LSR:     rd_mux = not_empty ? (LSR_IDLE | LSR_DR) : LSR_IDLE;
			REG_MSR: begin
				if (loopback) begin
					rd_mux = (mcr_q[MCR_RTS_BIT] ? MSR_LOOP_CTS : '0) |
						(mcr_q[MCR_DTR_BIT] ? MSR_LOOP_DSR : '0);
				end else begin
					rd_mux = MSR_NORMAL;
				end
			end
			REG_SCR:     rd_mux = scr_q;
			default:     rd_mux = '0;
		endcase
		if (!is_read) begin
			rd_mux = '0;
		end
	end

	// result of this item
	assign free_w = FW'(RX_DEPTH) - FW'(cnt_d);

	always_comb begin
		res           = '0;
		res.pop       = do_pop;
		res.read_data = rd_mux;
		res.irq       = (ier_d[IER_RX_BIT] && (cnt_d != '0)) ||
			(ier_d[IER_THR_BIT] && thr_empty_d);
		res.tx_valid  = thr_write && !loopback;
		res.tx_data   = (thr_write && !loopback) ? step.data : '0;
		res.rx_free   = free_w[RX_FREE_W-1:0];
	end

	// state update when the item passes to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			cnt_q       <= '0;
			lcr_q       <= '0;
			mcr_q       <= '0;
			ier_q       <= '0;
			dll_q       <= '0;
			dlm_q       <= '0;
			scr_q       <= '0;
			fifo_on_q   <= 1'b0;
			thr_empty_q <= 1'b0;
		end else if (fire) begin
			head_q      <= head_d;
			cnt_q       <= cnt_d;
			ier_q       <= ier_d;
			thr_empty_q <= thr_empty_d;
			if (is_write) begin
				case (sel)
					REG_RBR_THR: begin
						if (dlab) begin
							dll_q <= step.data;
						end
					end
					REG_IER: begin
						if (dlab) begin
							dlm_q <= step.data;
						end
					end
					REG_IIR_FCR: fifo_on_q <= step.data[FCR_EN_BIT];
					REG_LCR:     lcr_q <= step.data;
					REG_MCR:     mcr_q <= step.data;
					REG_SCR:     scr_q <= step.data;
					default: ;
				endcase
			end
		end
	end

endmodule

### hw/rtl/u16550_chk.sv
// Port-level checks on the UART register block's result channel.
// Depends on u16550_pkg; bound to uart_16550_register_model below.
module u16550_chk import u16550_pkg::*; #(
	parameter int RX_DEPTH = RX_DEPTH_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 res_valid,
	input logic                 res_ready,
	input logic [BYTE_W-1:0]    read_data,
	input logic                 tx_valid,
	input logic [BYTE_W-1:0]    tx_data,
	input logic [RX_FREE_W-1:0] rx_free
);

	// no result beat offered while in reset
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !res_valid)
		else $error("result offered during reset");

	// a stalled beat stays and holds its payload, irq apart
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(read_data) &&
		$stable(tx_valid) && $stable(tx_data) && $stable(rx_free))
		else $error("stalled result beat changed");

	// transmit byte is zero unless a byte is sent
	a_tx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !tx_valid |-> tx_data == '0)
		else $error("tx_data set without tx_valid");

	// free count never exceeds the store depth
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> 32'(rx_free) <= 32'(RX_DEPTH))
		else $error("rx_free above store depth");

endmodule

bind uart_16550_register_model u16550_chk #(
	.RX_DEPTH (RX_DEPTH)
) u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.read_data (result.read_data),
	.tx_valid  (result.tx_valid),
	.tx_data   (result.tx_data),
	.rx_free   (result.rx_free)
);

### test/tb_uart_16550_register_model.sv
// Self-checking testbench for the 16550-style UART register block: bus reads,
// bus writes and line characters are checked beat by beat against a predictor.
// Depends on u16550_pkg, the u16550 channel interfaces and the block's top level.
module tb_uart_16550_register_model;
	import u16550_pkg::*;

	localparam int RX_DEPTH       = RX_DEPTH_DEF;
	localparam int LOOPBACK_LIMIT = LOOPBACK_LIMIT_DEF;
	localparam int REG_SPAN       = 8;
	localparam int PHASES         = 5;
	localparam int PHASE_ITEMS    = 90;
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

	// One result beat as seen on the result channel
	typedef struct packed {
		logic [BYTE_W-1:0]    read_data;
		logic                 irq;
		logic                 tx_valid;
		logic [BYTE_W-1:0]    tx_data;
		logic [RX_FREE_W-1:0] rx_free;
	} uart_response_t;

	typedef struct {
		uart_response_t fields;
		int unsigned    seq;
	} tagged_response_t;

	// Register file and receive FIFO of the UART, with the responses still due
	class uart_reg_scoreboard;
		logic [ADDR_W-1:0] base_addr;
		logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
		int unsigned       rx_rd_ptr;
		int unsigned       rx_level;
		logic [BYTE_W-1:0] line_ctrl;
		logic [BYTE_W-1:0] modem_ctrl;
		logic [IER_W-1:0]  int_enable;
		logic [BYTE_W-1:0] div_lo;
		logic [BYTE_W-1:0] div_hi;
		logic [BYTE_W-1:0] scratch_reg;
		logic [BYTE_W-1:0] fifo_ctrl;
		logic              fifo_enabled;
		logic              thr_written;
		tagged_response_t  responses_due[$];
		int unsigned       accepted;
		int unsigned       error_count;

		function new();
			base_addr    = '0;
			rx_rd_ptr    = 0;
			rx_level     = 0;
			line_ctrl    = '0;
			modem_ctrl   = '0;
			int_enable   = '0;
			div_lo       = '0;
			div_hi       = '0;
			scratch_reg  = '0;
			fifo_ctrl    = '0;
			fifo_enabled = 1'b0;
			thr_written  = 1'b0;
			accepted     = 0;
			error_count  = 0;
		endfunction

		function void set_base(logic [ADDR_W-1:0] value);
			base_addr = value;
		endfunction

		function int unsigned outstanding();
			return responses_due.size();
		endfunction

		// Characters beyond the depth are dropped
		function void rx_push(logic [BYTE_W-1:0] ch);
			if (rx_level >= RX_DEPTH)
				return;
			rx_mem[(rx_rd_ptr + rx_level) % RX_DEPTH] = ch;
			rx_level++;
		endfunction

		function logic [BYTE_W-1:0] rx_pop();
			logic [BYTE_W-1:0] ch;
			if (rx_level == 0)
				return '0;
			ch        = rx_mem[rx_rd_ptr];
			rx_rd_ptr = (rx_rd_ptr + 1) % RX_DEPTH;
			rx_level--;
			return ch;
		endfunction

		// Receive data outranks THR empty
		function logic [BYTE_W-1:0] iir_code();
			logic [BYTE_W-1:0] flag;
			flag = fifo_enabled ? IIR_FIFO_FLAG : '0;
			if (int_enable[IER_RX_BIT] && rx_level != 0)
				return IIR_RX_CODE | flag;
			if (int_enable[IER_THR_BIT] && thr_written)
				return IIR_THR_CODE | flag;
			return IIR_NONE_CODE | flag;
		endfunction

		// Apply one accepted beat and queue the response it causes
		function void note_access(logic [KIND_W-1:0] kind_code, logic [ADDR_W-1:0] address,
				logic [BYTE_W-1:0] data);
			logic [ADDR_W-1:0] offset;
			logic              dlab;
			logic [BYTE_W-1:0] iir;
			int unsigned       free_cnt;
			uart_response_t    resp;
			offset = address - base_addr;
			dlab   = line_ctrl[LCR_DLAB_BIT];
			resp   = '0;
			if (kind_code == KIND_READ) begin
				if (offset < REG_SPAN) begin
					case (offset[REG_SEL_W-1:0])
						REG_RBR_THR: resp.read_data = dlab ? div_lo : rx_pop();
						REG_IER:     resp.read_data = dlab ? div_hi : {4'b0, int_enable};
						REG_IIR_FCR: resp.read_data = iir_code();
						REG_LCR:     resp.read_data = line_ctrl;
						REG_MCR:     resp.read_data = modem_ctrl;
						REG_LSR:     resp.read_data = LSR_IDLE | ((rx_level != 0) ? LSR_DR : '0);
						REG_MSR: begin
							if (modem_ctrl[MCR_LOOP_BIT]) begin
								if (modem_ctrl[MCR_RTS_BIT])
									resp.read_data |= MSR_LOOP_CTS;
								if (modem_ctrl[MCR_DTR_BIT])
									resp.read_data |= MSR_LOOP_DSR;
							end else begin
								resp.read_data = MSR_NORMAL;
							end
						end
						default:     resp.read_data = scratch_reg;
					endcase
				end
			end else if (kind_code == KIND_WRITE) begin
				if (offset < REG_SPAN) begin
					case (offset[REG_SEL_W-1:0])
						REG_RBR_THR: begin
							if (dlab) begin
								div_lo = data;
							end else begin
								// loopback feeds the receive FIFO up to its limit
								if (modem_ctrl[MCR_LOOP_BIT]) begin
									if (rx_level < LOOPBACK_LIMIT)
										rx_push(data);
								end else begin
									resp.tx_valid = 1'b1;
									resp.tx_data  = data;
								end
								thr_written = 1'b1;
							end
						end
						REG_IER: begin
							if (dlab)
								div_hi = data;
							else
								int_enable = data[IER_W-1:0];
						end
						REG_IIR_FCR: begin
							fifo_ctrl    = data;
							fifo_enabled = data[FCR_EN_BIT];
							if (data[FCR_CLR_BIT]) begin
								rx_rd_ptr = 0;
								rx_level  = 0;
							end
						end
						REG_LCR: line_ctrl   = data;
						REG_MCR: modem_ctrl  = data;
						REG_SCR: scratch_reg = data;
						default: ;
					endcase
				end
			end else if (kind_code == KIND_RX) begin
				rx_push(data);
			end
			free_cnt     = (rx_level >= RX_DEPTH) ? 0 : RX_DEPTH - rx_level;
			resp.rx_free = free_cnt[RX_FREE_W-1:0];
			iir          = iir_code();
			resp.irq     = ~iir[0];
			responses_due.push_back('{fields: resp, seq: accepted});
			accepted++;
		endfunction

		task report_mismatch(string msg);
			error_count++;
			$display("ERROR: %s", msg);
		endtask

		// Compare one result beat with the oldest response due
		task check_response(uart_response_t got);
			tagged_response_t due;
			if (responses_due.size() == 0) begin
				report_mismatch($sformatf("result beat with no access outstanding: %h", got));
				return;
			end
			due = responses_due.pop_front();
			if (got.read_data !== due.fields.read_data)
				report_mismatch($sformatf("item %0d read_data %h, expected %h",
					due.seq, got.read_data, due.fields.read_data));
			if (got.irq !== due.fields.irq)
				report_mismatch($sformatf("item %0d irq %b, expected %b",
					due.seq, got.irq, due.fields.irq));
			if (got.tx_valid !== due.fields.tx_valid)
				report_mismatch($sformatf("item %0d tx_valid %b, expected %b",
					due.seq, got.tx_valid, due.fields.tx_valid));
			if (got.tx_data !== due.fields.tx_data)
				report_mismatch($sformatf("item %0d tx_data %h, expected %h",
					due.seq, got.tx_data, due.fields.tx_data));
			if (got.rx_free !== due.fields.rx_free)
				report_mismatch($sformatf("item %0d rx_free %0d, expected %0d",
					due.seq, got.rx_free, due.fields.rx_free));
		endtask
	endclass

	logic clk;
	logic arst_n;

	u16550_cfg_if    cfg_ch ();
	u16550_item_if   item_ch ();
	u16550_result_if result_ch ();

	uart_16550_register_model i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (item_ch),
		.result (result_ch)
	);

	uart_reg_scoreboard scoreboard = new();
	uart_response_t     seen_response;
	logic [ADDR_W-1:0]  cur_base;
	int unsigned        src_idle_pct;
	int unsigned        sink_stall_pct;

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Run limit
	initial begin
		#5000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Result sink with random stalls
	initial begin : response_sink
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Observe every beat at the rising edge
	always @(posedge clk) begin
		if (cfg_ch.valid && cfg_ch.ready)
			scoreboard.set_base(cfg_ch.data);
		if (item_ch.valid && item_ch.ready)
			scoreboard.note_access(item_ch.kind, item_ch.address, item_ch.data);
		if (result_ch.valid && result_ch.ready) begin
			seen_response.read_data = result_ch.read_data;
			seen_response.irq       = result_ch.irq;
			seen_response.tx_valid  = result_ch.tx_valid;
			seen_response.tx_data   = result_ch.tx_data;
			seen_response.rx_free   = result_ch.rx_free;
			scoreboard.check_response(seen_response);
		end
	end

	// Offer one item, idling first at the current rate, and wait for its beat
	task send_item(logic [KIND_W-1:0] kind_code, logic [ADDR_W-1:0] address,
			logic [BYTE_W-1:0] data);
		while ($urandom_range(99) < src_idle_pct) begin
			@(negedge clk);
			item_ch.valid <= 1'b0;
		end
		@(negedge clk);
		item_ch.valid   <= 1'b1;
		item_ch.kind    <= kind_code;
		item_ch.address <= address;
		item_ch.data    <= data;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	task send_read(logic [REG_SEL_W-1:0] reg_sel);
		send_item(KIND_READ, cur_base + reg_sel, BYTE_W'($urandom));
	endtask

	task send_write(logic [REG_SEL_W-1:0] reg_sel, logic [BYTE_W-1:0] data);
		send_item(KIND_WRITE, cur_base + reg_sel, data);
	endtask

	task send_rx(logic [BYTE_W-1:0] data);
		send_item(KIND_RX, ADDR_W'($urandom), data);
	endtask

	// Stop offering items until every response has come back
	task drain_responses();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (scoreboard.outstanding() != 0)
			@(posedge clk);
	endtask

	// Base address write; only called with nothing outstanding
	task write_base(logic [ADDR_W-1:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		cur_base = value;
	endtask

	// Mostly register offsets, some just beyond the window, a few anywhere
	function logic [ADDR_W-1:0] pick_address();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 88)
			return cur_base + $urandom_range(0, REG_SPAN - 1);
		if (r < 95)
			return cur_base + $urandom_range(REG_SPAN, 300);
		return ADDR_W'($urandom);
	endfunction

	// Random traffic: line bursts, RBR drains, loopback runs, response drains and single accesses
	task run_random_phase(int unsigned n_items);
		int unsigned       done;
		int unsigned       pick;
		int unsigned       burst;
		logic [KIND_W-1:0] kind_code;
		logic [ADDR_W-1:0] address;
		logic [BYTE_W-1:0] data;
		done = 0;
		while (done < n_items) begin
			pick = $urandom_range(99);
			if (pick < 14) begin
				// long enough now and then to overrun the FIFO
				burst = $urandom_range(1, RX_DEPTH + 8);
				for (int i = 0; i < burst; i++)
					send_rx(BYTE_W'($urandom));
				done += burst;
			end else if (pick < 24) begin
				send_write(REG_LCR, BYTE_W'($urandom_range(0, 127)));
				burst = $urandom_range(1, RX_DEPTH + 4);
				for (int i = 0; i < burst; i++)
					send_read(REG_RBR_THR);
				done += burst + 1;
			end else if (pick < 34) begin
				send_write(REG_LCR, BYTE_W'($urandom_range(0, 127)));
				send_write(REG_MCR, BYTE_W'($urandom) | (1 << MCR_LOOP_BIT));
				burst = $urandom_range(1, LOOPBACK_LIMIT + 6);
				for (int i = 0; i < burst; i++)
					send_write(REG_RBR_THR, BYTE_W'($urandom));
				send_write(REG_MCR, BYTE_W'($urandom));
				done += burst + 3;
			end else if (pick < 36) begin
				drain_responses();
			end else begin
				kind_code = ($urandom_range(99) < 2) ? KIND_SPARE : KIND_W'($urandom_range(0, 2));
				address   = pick_address();
				data      = BYTE_W'($urandom);
				// keep FIFO clears rarer than other FCR bits
				if (kind_code == KIND_WRITE && address - cur_base == REG_IIR_FCR)
					data[FCR_CLR_BIT] = ($urandom_range(3) == 0);
				send_item(kind_code, address, data);
				done++;
			end
		end
	endtask

	initial begin : stimulus
		int unsigned       src_pace [4];
		int unsigned       sink_pace [4];
		logic [ADDR_W-1:0] base_plan [PHASES];
		src_pace  = '{0, 71, 0, 28};
		sink_pace = '{0, 0, 71, 28};
		base_plan = '{32'h0000_0000, 32'hFFFF_FFFF, ADDR_W'($urandom), 32'hFFFF_FFFC,
			ADDR_W'($urandom) & ~32'h7};
		arst_n          = 1'b0;
		item_ch.valid   = 1'b0;
		item_ch.kind    = KIND_READ;
		item_ch.address = '0;
		item_ch.data    = '0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.data     = '0;
		cur_base        = '0;
		src_idle_pct    = 0;
		sink_stall_pct  = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: reset values, window edges, banking, masking, loopback, transmit
		write_base('0);
		for (int i = 0; i < REG_SPAN; i++)
			send_read(REG_SEL_W'(i));
		send_item(KIND_SPARE, cur_base + REG_LCR, 8'hFF);
		send_item(KIND_WRITE, cur_base + REG_SPAN, 8'hFF);
		send_item(KIND_READ, 32'hFFFF_FFFF, 8'h00);
		send_write(REG_IER, 8'hFF);
		send_read(REG_IER);
		send_write(REG_LCR, 8'h80);
		send_write(REG_RBR_THR, 8'hFF);
		send_write(REG_IER, 8'h5A);
		send_read(REG_RBR_THR);
		send_write(REG_LCR, 8'h03);
		send_write(REG_IIR_FCR, 8'h03);
		send_write(REG_MCR, 8'h13);
		send_write(REG_RBR_THR, 8'h00);
		send_rx(8'hFF);
		send_read(REG_RBR_THR);
		send_write(REG_MCR, 8'h00);
		send_write(REG_RBR_THR, 8'h80);

		// Random phases, each under its own base address and one of four pacings
		for (int p = 0; p < PHASES; p++) begin
			drain_responses();
			write_base(base_plan[p]);
			src_idle_pct   = src_pace[p % 4];
			sink_stall_pct = sink_pace[p % 4];
			run_random_phase(PHASE_ITEMS);
		end

		drain_responses();
		repeat (8) @(posedge clk);
		if (scoreboard.outstanding() != 0)
			scoreboard.report_mismatch($sformatf("%0d responses never arrived",
				scoreboard.outstanding()));
		if (scoreboard.error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/u16550_pkg.sv
hw/rtl/u16550_if.sv
hw/rtl/u16550_ram.sv
hw/rtl/u16550_regs.sv
hw/rtl/uart_16550_register_model.sv
hw/rtl/u16550_chk.sv
test/tb_uart_16550_register_model.sv
